// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic signed [7:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic signed [7:0]  out_priority;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       latch;
    logic       insert;
    logic       remove;
    logic       rotate;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_data;
    logic       emit_last;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       empty;
    logic       full;
    logic       read_last;
  } ctl_sts_t;

endpackage

// ----- src/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accepts a command beat, runs it on the datapath, paces readout.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output spq_pkg::ctl_cmd_t cmd,
  input  spq_pkg::ctl_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit_status = spq_pkg::STATUS_OK;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        case (sts.func)
          spq_pkg::FUNC_INSERT: begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.insert      = !sts.full;
            cmd.emit_status = sts.full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
          end
          spq_pkg::FUNC_DELETE: begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.remove      = !sts.empty;
            cmd.emit_data   = !sts.empty;
            cmd.emit_status = sts.empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
          end
          spq_pkg::FUNC_READ: begin
            if (sts.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = spq_pkg::STATUS_EMPTY;
            end else begin
              state_next = ST_READ;
            end
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        // head goes out while the occupied cells rotate by one
        cmd.rotate    = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_data = 1'b1;
        cmd.emit_last = sts.read_last;
        if (sts.read_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !sts.empty)
    else $error("readout running on an empty queue");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_EXEC))
    else $error("accepted beat not executed");

  a_no_double_move: assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert && (cmd.remove || cmd.rotate)))
    else $error("insert issued together with a shift");
`endif

endmodule

// ----- src/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted cell array with parallel compare-and-shift, fill count, result reg.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::in_item_t  in_item,
  input  spq_pkg::ctl_cmd_t  cmd,
  output spq_pkg::ctl_sts_t  sts,
  output spq_pkg::out_item_t result,
  output logic               strobe
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] val_q [DEPTH];
  logic signed [7:0]  pri_q [DEPTH];
  logic signed [31:0] val_next [DEPTH];
  logic signed [7:0]  pri_next [DEPTH];
  logic [DEPTH-1:0]   le;

  logic [CW-1:0]      count;
  logic [IW-1:0]      rd_idx;
  spq_pkg::in_item_t  item;

  assign sts.func      = item.func;
  assign sts.empty     = (count == '0);
  assign sts.full      = (count == CW'(DEPTH));
  assign sts.read_last = ((CW'(rd_idx) + CW'(1)) == count);

  // occupied cells whose priority is at or ahead of the new one form a prefix
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic le_prev;
    logic wrap;
    logic signed [31:0] right_val;
    logic signed [7:0]  right_pri;

    assign le[i] = (CW'(i) < count) && (pri_q[i] <= item.priority_req);
    assign wrap  = ((CW'(i) + CW'(1)) == count);

    if (i == 0) begin : g_head
      assign le_prev = 1'b1;
    end else begin : g_body
      assign le_prev = le[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = val_q[i];
      assign right_pri = pri_q[i];
    end else begin : g_mid
      assign right_val = val_q[i+1];
      assign right_pri = pri_q[i+1];
    end

    always_comb begin
      val_next[i] = val_q[i];
      pri_next[i] = pri_q[i];
      if (cmd.insert && !le[i]) begin
        if (le_prev) begin
          val_next[i] = item.value;
          pri_next[i] = item.priority_req;
        end else if (i > 0) begin
          val_next[i] = val_q[(i > 0) ? i - 1 : 0];
          pri_next[i] = pri_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.remove || cmd.rotate) begin
        // head wraps into the last occupied cell; after a delete it is dead
        if (wrap) begin
          val_next[i] = val_q[0];
          pri_next[i] = pri_q[0];
        end else begin
          val_next[i] = right_val;
          pri_next[i] = right_pri;
        end
      end
    end

    always_ff @(posedge clk) begin
      val_q[i] <= val_next[i];
      pri_q[i] <= pri_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.insert) begin
        count <= count + CW'(1);
      end else if (cmd.remove) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item   <= in_item;
      rd_idx <= '0;
    end else if (cmd.rotate) begin
      rd_idx <= rd_idx + IW'(1);
    end
    if (cmd.emit) begin
      result.status       <= cmd.emit_status;
      result.out_value    <= cmd.emit_data ? val_q[0] : '0;
      result.out_priority <= cmd.emit_data ? pri_q[0] : '0;
      result.last         <= cmd.emit_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the queue");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |=> (count == $past(count) - CW'(1)))
    else $error("delete did not shrink the queue");

  a_rotate_count: assert property (@(posedge clk) disable iff (rst)
    cmd.rotate |=> $stable(count))
    else $error("readout changed the fill count");
`endif

endmodule

// ----- src/stable_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded, stable priority queue with insert, delete-head and readout.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Insert and
// delete execute in the cycle after acceptance, with busy high, so the next
// command is taken back in idle; their single result shows on the result port
// with strobe high in the following cycle. A readout holds busy through its
// execute and readout states and drives one result per cycle, head first,
// last set on the final one, as the controller rotates the cell array by one
// entry per cycle to bring each entry to the head. Every result is shown with
// strobe high for exactly one cycle, whether or not it is taken.
module stable_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_item_t  in_item,
  output logic               strobe,
  output spq_pkg::out_item_t result
);

  spq_pkg::ctl_cmd_t cmd;
  spq_pkg::ctl_sts_t sts;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result),
    .strobe  (strobe)
  );

endmodule

// ----- dv/tb_stable_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_top
// Self-checking bench for the stable priority queue: a clocked driver issues
// insert, delete, readout and unused-selector commands from a pending list
// with random gaps, a shadow copy of the sorted store predicts every result
// beat and a clocked monitor checks each strobed result field by field in order.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH         = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BEATS   = 200;

  typedef struct {
    spq_pkg::in_item_t item;
    bit                drain;   // hold the sender until all results are back
  } cmd_slot_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  spq_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               strobe;
  spq_pkg::out_item_t result;

  cmd_slot_t          pending_cmds [$];
  spq_pkg::out_item_t expected_results [$];

  // shadow of the sorted store
  logic signed [31:0] shadow_val [QDEPTH];
  logic signed [7:0]  shadow_pri [QDEPTH];
  int                 shadow_len = 0;

  int errors        = 0;
  int results_seen  = 0;
  int n_insert      = 0;
  int n_delete      = 0;
  int n_readout     = 0;
  int n_ignored     = 0;
  int n_full        = 0;
  int n_empty       = 0;
  int gap_left      = 0;
  int idle_cycles   = 0;
  bit steady        = 1'b0;

  stable_priority_queue_top #(.DEPTH(QDEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .strobe  (strobe),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s after %0d results: got %h, want %h", field,
             results_seen, got, want);
    errors++;
  endtask

  // works out the result beats that one accepted command causes
  task automatic predict_queue(input spq_pkg::in_item_t cmd);
    spq_pkg::out_item_t r;
    int pos;
    int i;
    r = '0;
    r.last = 1'b1;
    case (cmd.func)
      spq_pkg::FUNC_INSERT: begin
        n_insert++;
        if (shadow_len >= QDEPTH) begin
          n_full++;
          r.status = spq_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_len &&
                 $signed(shadow_pri[pos]) <= $signed(cmd.priority_req))
            pos++;
          for (i = shadow_len; i > pos; i--) begin
            shadow_val[i] = shadow_val[i-1];
            shadow_pri[i] = shadow_pri[i-1];
          end
          shadow_val[pos] = cmd.value;
          shadow_pri[pos] = cmd.priority_req;
          shadow_len++;
          r.status = spq_pkg::STATUS_OK;
        end
        expected_results.push_back(r);
      end
      spq_pkg::FUNC_DELETE: begin
        n_delete++;
        if (shadow_len == 0) begin
          n_empty++;
          r.status = spq_pkg::STATUS_EMPTY;
        end else begin
          r.status       = spq_pkg::STATUS_OK;
          r.out_value    = shadow_val[0];
          r.out_priority = shadow_pri[0];
          for (i = 0; i + 1 < shadow_len; i++) begin
            shadow_val[i] = shadow_val[i+1];
            shadow_pri[i] = shadow_pri[i+1];
          end
          shadow_len--;
        end
        expected_results.push_back(r);
      end
      spq_pkg::FUNC_READ: begin
        n_readout++;
        if (shadow_len == 0) begin
          n_empty++;
          r.status = spq_pkg::STATUS_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            r.status       = spq_pkg::STATUS_OK;
            r.out_value    = shadow_val[i];
            r.out_priority = shadow_pri[i];
            r.last         = (i + 1 == shadow_len);
            expected_results.push_back(r);
          end
        end
      end
      default: n_ignored++;
    endcase
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (steady || roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    bit taken;
    if (rst) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        predict_queue(in_item);
        void'(pending_cmds.pop_front());
        if ($urandom_range(0, 24) == 0) steady = !steady;
        gap_left = pick_gap();
      end
      if (start && !taken) begin
        // keep the beat on the port until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0 && pending_cmds[0].drain) begin
        start <= 1'b0;
        if (expected_results.size() == 0 && !busy) void'(pending_cmds.pop_front());
      end else if (pending_cmds.size() > 0) begin
        start   <= 1'b1;
        in_item <= pending_cmds[0].item;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    spq_pkg::out_item_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $display("result beat with nothing expected: %p", result);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", 32'(result.status), 32'(want.status));
        if (result.out_value !== want.out_value)
          report_mismatch("out_value", result.out_value, want.out_value);
        if (result.out_priority !== want.out_priority)
          report_mismatch("out_priority", 32'(result.out_priority),
                          32'(want.out_priority));
        if (result.last !== want.last)
          report_mismatch("last", 32'(result.last), 32'(want.last));
      end
      results_seen++;
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("tb_stable_priority_queue_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_cmd(input logic [1:0] func, input logic [31:0] value,
                          input logic [7:0] pri);
    cmd_slot_t s;
    s.item.func         = func;
    s.item.value        = value;
    s.item.priority_req = pri;
    s.drain             = 1'b0;
    pending_cmds.push_back(s);
  endtask

  task automatic push_drain();
    cmd_slot_t s;
    s.item  = '0;
    s.drain = 1'b1;
    pending_cmds.push_back(s);
  endtask

  function automatic logic [7:0] rand_pri();
    // narrow pool half the time so equal priorities are common
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 3) - 2);
    return 8'($urandom);
  endfunction

  initial begin
    int count;
    int burst;
    int mode;
    int k;
    bit drained_mid;

    // directed: empty cases, extremes, ties, unused selector
    push_cmd(spq_pkg::FUNC_READ,   $urandom, 8'($urandom));
    push_cmd(spq_pkg::FUNC_DELETE, $urandom, 8'($urandom));
    push_cmd(spq_pkg::FUNC_INSERT, 32'h7fff_ffff, 8'h7f);
    push_cmd(spq_pkg::FUNC_INSERT, 32'h8000_0000, 8'h80);
    push_cmd(spq_pkg::FUNC_INSERT, 32'h0000_0000, 8'h00);
    push_cmd(spq_pkg::FUNC_INSERT, 32'h0000_0001, 8'h00);
    push_cmd(spq_pkg::FUNC_INSERT, 32'hffff_ffff, 8'h00);
    push_cmd(spq_pkg::FUNC_INSERT, 32'h5a5a_a5a5, 8'hff);
    push_cmd(spq_pkg::FUNC_INSERT, 32'ha5a5_5a5a, 8'h7f);
    push_cmd(spq_pkg::FUNC_INSERT, 32'h1234_5678, 8'h80);
    push_cmd(spq_pkg::FUNC_READ,   32'hffff_ffff, 8'hff);
    push_cmd(2'd3,                 32'hffff_ffff, 8'hff);
    push_cmd(spq_pkg::FUNC_DELETE, 32'hffff_ffff, 8'hff);
    push_cmd(spq_pkg::FUNC_DELETE, 32'h0,         8'h0);
    push_cmd(spq_pkg::FUNC_READ,   32'h0,         8'h0);
    push_drain();

    // random: insert and delete bursts drive the store to full and empty
    count = 0;
    drained_mid = 1'b0;
    while (count < RANDOM_BEATS) begin
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
        burst = $urandom_range(1, 20);
        for (k = 0; k < burst; k++)
          push_cmd(spq_pkg::FUNC_INSERT, $urandom, rand_pri());
        count += burst;
      end else if (mode <= 6) begin
        burst = $urandom_range(1, 20);
        for (k = 0; k < burst; k++)
          push_cmd(spq_pkg::FUNC_DELETE, $urandom, 8'($urandom));
        count += burst;
      end else if (mode <= 8) begin
        push_cmd(spq_pkg::FUNC_READ, $urandom, 8'($urandom));
        count++;
      end else begin
        push_cmd(2'd3, $urandom, 8'($urandom));
      end
      if (!drained_mid && count >= RANDOM_BEATS / 2) begin
        push_drain();
        drained_mid = 1'b1;
      end
    end
    push_cmd(spq_pkg::FUNC_READ, $urandom, 8'($urandom));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
    repeat (2 * QDEPTH + 8) @(posedge clk);

    $display("covered %0d inserts, %0d deletes, %0d readouts, %0d ignored selectors",
             n_insert, n_delete, n_readout, n_ignored);
    $display("%0d full rejections, %0d empty reports, %0d result beats checked",
             n_full, n_empty, results_seen);
    if (errors == 0) begin
      $display("tb_stable_priority_queue_top: done, clean");
    end else begin
      $display("tb_stable_priority_queue_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue_top.sv
dv/tb_stable_priority_queue_top.sv
